[rtl/r40c_pkg.sv]
// Shared constants, types and symbol mapping functions for the radix-40 callsign codec.
package r40c_pkg;

   // Characters per radix-40 chunk. The datapath splits a chunk into two groups of
   // three symbols (40^3 = 64000), so the arithmetic below is built for six.
   localparam int CHUNK_CHARS = 6;
   localparam int TOTAL_CHARS = 2 * CHUNK_CHARS;
   localparam int GROUP_CHARS = CHUNK_CHARS / 2;
   localparam int NUM_GROUPS  = TOTAL_CHARS / GROUP_CHARS;
   localparam int STAGES      = 5;

   localparam int CHAR_W  = 8;
   localparam int SYM_W   = 6;
   localparam int CODE_W  = 32;
   localparam int CHARS_W = CHUNK_CHARS * CHAR_W;
   localparam int COUNT_W = 4;
   localparam int VPN_W   = 16;
   localparam int GROUP_W = 16;
   localparam int HALF_W  = 17;

   // Reciprocals for exact division by constants.
   // code / 64000 = (code >> 9) / 125 = ((code >> 9) * RECIP_125) >> RECIP_125_SHIFT.
   localparam logic [23:0] RECIP_125       = 24'd8589935;
   localparam int          RECIP_125_SHIFT = 30;
   // v / 1600 = (v >> 6) / 25.
   localparam logic [10:0] RECIP_25        = 11'd1311;
   localparam int          RECIP_25_SHIFT  = 15;
   // r / 40 = (r >> 3) / 5.
   localparam logic [7:0]  RECIP_5         = 8'd205;
   localparam int          RECIP_5_SHIFT   = 10;

   localparam logic [SYM_W-1:0] RADIX      = 6'd40;
   localparam logic [SYM_W-1:0] SYM_SPACE  = 6'd10;
   localparam logic [SYM_W-1:0] SYM_ALPHA  = 6'd11;
   localparam logic [SYM_W-1:0] SYM_OPEN   = 6'd37;
   localparam logic [SYM_W-1:0] SYM_CLOSE  = 6'd38;
   localparam logic [SYM_W-1:0] SYM_DASH   = 6'd39;

   localparam logic [CHAR_W-1:0]  ASCII_SPACE = 8'h20;
   localparam logic [CODE_W-1:0]  BCAST_CODE  = 32'hFFFF_FFFF;
   localparam logic [VPN_W-1:0]   BCAST_VPN   = 16'hFFFF;
   localparam logic [31:0]        BCAST_NAME  = 32'h4646_4646;
   localparam logic [COUNT_W-1:0] BCAST_LEN   = 4'd4;

   typedef logic [SYM_W-1:0] sym_type;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } stage_ctrl_type;

   function automatic sym_type sym_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] u;
      u = c;
      if (c >= "a" && c <= "z") begin
         u = c - 8'h20;
      end
      priority if (u >= "0" && u <= "9") begin
         sym_of = SYM_W'(u - "0");
      end else if (u == " ") begin
         sym_of = SYM_SPACE;
      end else if (u >= "A" && u <= "Z") begin
         sym_of = SYM_W'(u - "A") + SYM_ALPHA;
      end else if (u == "(") begin
         sym_of = SYM_OPEN;
      end else if (u == ")") begin
         sym_of = SYM_CLOSE;
      end else if (u == "-") begin
         sym_of = SYM_DASH;
      end else begin
         sym_of = '0;
      end
   endfunction

   function automatic logic [CHAR_W-1:0] char_of(input sym_type s);
      priority if (s <= 6'd9) begin
         char_of = "0" + CHAR_W'(s);
      end else if (s == SYM_SPACE) begin
         char_of = ASCII_SPACE;
      end else if (s == SYM_OPEN) begin
         char_of = "(";
      end else if (s == SYM_CLOSE) begin
         char_of = ")";
      end else if (s == SYM_DASH) begin
         char_of = "-";
      end else begin
         char_of = "A" + CHAR_W'(s - SYM_ALPHA);
      end
   endfunction

endpackage

[rtl/r40c_if.sv]
// Request and response channel interfaces of the radix-40 callsign codec.
interface r40c_req_if;
   import r40c_pkg::*;
   logic                valid;
   logic                ready;
   logic                mode;
   logic [CHARS_W-1:0]  first_chars;
   logic [CHARS_W-1:0]  ext_chars;
   logic [COUNT_W-1:0]  char_count;
   logic [VPN_W-1:0]    vpn_in;
   logic [CODE_W-1:0]   code_main_in;
   logic [CODE_W-1:0]   code_ext_in;
   logic                ext_present_in;

   modport source (
      output valid, mode, first_chars, ext_chars, char_count, vpn_in,
             code_main_in, code_ext_in, ext_present_in,
      input  ready
   );
   modport sink (
      input  valid, mode, first_chars, ext_chars, char_count, vpn_in,
             code_main_in, code_ext_in, ext_present_in,
      output ready
   );
endinterface

interface r40c_rsp_if;
   import r40c_pkg::*;
   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   code_main;
   logic [CODE_W-1:0]   code_ext;
   logic                ext_flag;
   logic                is_broadcast;
   logic [VPN_W-1:0]    vpn_out;
   logic [CHARS_W-1:0]  chars_main_out;
   logic [CHARS_W-1:0]  chars_ext_out;

   modport source (
      output valid, code_main, code_ext, ext_flag, is_broadcast, vpn_out,
             chars_main_out, chars_ext_out,
      input  ready
   );
   modport sink (
      input  valid, code_main, code_ext, ext_flag, is_broadcast, vpn_out,
             chars_main_out, chars_ext_out,
      output ready
   );
endinterface

[rtl/r40c_pipe_ctrl.sv]
// Valid tracking and per-stage load enables for the codec pipeline.
module r40c_pipe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output r40c_pkg::stage_ctrl_type ctrl
);
   import r40c_pkg::*;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] load;

   // A stage loads when it is empty or its content moves on; this closes bubbles.
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load = load;
   assign req_ready = load[0];
   assign rsp_valid = valid_ff[STAGES-1];
endmodule

[rtl/r40c_encode.sv]
// Encode datapath: symbol mapping, three-symbol groups and radix-40 chunk codes.
module r40c_encode (
   input  logic                              clock,
   input  r40c_pkg::stage_ctrl_type          ctrl,
   input  logic                              mode,
   input  logic [r40c_pkg::CHARS_W-1:0]      first_chars,
   input  logic [r40c_pkg::CHARS_W-1:0]      ext_chars,
   input  logic [r40c_pkg::COUNT_W-1:0]      char_count,
   input  logic [r40c_pkg::VPN_W-1:0]        vpn_in,
   output logic [r40c_pkg::CODE_W-1:0]       code_main,
   output logic [r40c_pkg::CODE_W-1:0]       code_ext,
   output logic                              ext_flag,
   output logic                              is_broadcast,
   output logic [r40c_pkg::VPN_W-1:0]        vpn_out
);
   import r40c_pkg::*;

   typedef struct packed {
      logic              mode;
      logic              bcast;
      logic              ext;
      logic [VPN_W-1:0]  vpn;
   } enc_tag_type;

   function automatic logic [GROUP_W-1:0] group3(input sym_type a, input sym_type b,
                                                 input sym_type c);
      logic [GROUP_W-1:0] wa;
      logic [GROUP_W-1:0] wb;
      logic [GROUP_W-1:0] wc;
      wa = GROUP_W'(a);
      wb = GROUP_W'(b);
      wc = GROUP_W'(c);
      // a * 1600 + b * 40 + c
      return (wa << 10) + (wa << 9) + (wa << 6) + (wb << 5) + (wb << 3) + wc;
   endfunction

   logic [COUNT_W-1:0] cnt;
   logic [CHAR_W-1:0]  byte_v;
   enc_tag_type        tag_in;
   enc_tag_type        tag_ff [STAGES-1];

   sym_type            sym_in [TOTAL_CHARS];
   sym_type            sym_ff [TOTAL_CHARS];
   logic [GROUP_W-1:0] grp_in [NUM_GROUPS];
   logic [GROUP_W-1:0] grp_ff [NUM_GROUPS];
   logic [CODE_W-1:0]  upper_in [2];
   logic [CODE_W-1:0]  upper_ff [2];
   logic [GROUP_W-1:0] lower_ff [2];
   logic [CODE_W-1:0]  chunk_in [2];
   logic [CODE_W-1:0]  chunk_ff [2];

   logic [CODE_W-1:0]  code_main_in;
   logic [CODE_W-1:0]  code_ext_in;
   logic               ext_flag_in;
   logic               bcast_in;
   logic [VPN_W-1:0]   vpn_out_in;
   logic [CODE_W-1:0]  code_main_ff;
   logic [CODE_W-1:0]  code_ext_ff;
   logic               ext_flag_ff;
   logic               bcast_ff;
   logic [VPN_W-1:0]   vpn_out_ff;

   // Stage one: length clamp, blank padding, symbol lookup and broadcast detection.
   always_comb begin
      cnt = (char_count > COUNT_W'(TOTAL_CHARS)) ? COUNT_W'(TOTAL_CHARS) : char_count;
      for (int p = 0; p < TOTAL_CHARS; p++) begin
         if (p < CHUNK_CHARS) begin
            byte_v = first_chars[CHAR_W*(CHUNK_CHARS-1-p) +: CHAR_W];
         end else begin
            byte_v = ext_chars[CHAR_W*(TOTAL_CHARS-1-p) +: CHAR_W];
         end
         if (COUNT_W'(p) >= cnt) begin
            byte_v = ASCII_SPACE;
         end
         sym_in[p] = sym_of(byte_v);
      end
      tag_in.mode  = mode;
      tag_in.bcast = (cnt == BCAST_LEN) && (first_chars[CHARS_W-1 -: 32] == BCAST_NAME);
      tag_in.ext   = cnt > COUNT_W'(CHUNK_CHARS);
      tag_in.vpn   = vpn_in;
   end

   // Stage two: three symbols to one value below 64000.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_in[g] = group3(sym_ff[GROUP_CHARS*g], sym_ff[GROUP_CHARS*g+1],
                            sym_ff[GROUP_CHARS*g+2]);
      end
   end

   // Stages three and four: upper group times 64000, then the lower group is added.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         upper_in[k] = (CODE_W'(grp_ff[2*k]) << 16) - (CODE_W'(grp_ff[2*k]) << 10)
                       - (CODE_W'(grp_ff[2*k]) << 9);
         chunk_in[k] = upper_ff[k] + CODE_W'(lower_ff[k]);
      end
   end

   // Stage five: mode, broadcast and extension select the result fields.
   always_comb begin
      enc_tag_type t;
      t            = tag_ff[STAGES-2];
      bcast_in     = !t.mode && t.bcast;
      ext_flag_in  = !t.mode && !t.bcast && t.ext;
      code_main_in = t.mode ? '0 : (t.bcast ? BCAST_CODE : chunk_ff[0]);
      code_ext_in  = ext_flag_in ? chunk_ff[1] : '0;
      vpn_out_in   = bcast_in ? BCAST_VPN : t.vpn;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         sym_ff    <= sym_in;
         tag_ff[0] <= tag_in;
      end
      for (int i = 1; i < STAGES - 1; i++) begin
         if (ctrl.load[i]) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
      if (ctrl.load[1]) begin
         grp_ff <= grp_in;
      end
      if (ctrl.load[2]) begin
         upper_ff    <= upper_in;
         lower_ff[0] <= grp_ff[1];
         lower_ff[1] <= grp_ff[3];
      end
      if (ctrl.load[3]) begin
         chunk_ff <= chunk_in;
      end
      if (ctrl.load[4]) begin
         code_main_ff <= code_main_in;
         code_ext_ff  <= code_ext_in;
         ext_flag_ff  <= ext_flag_in;
         bcast_ff     <= bcast_in;
         vpn_out_ff   <= vpn_out_in;
      end
   end

   assign code_main    = code_main_ff;
   assign code_ext     = code_ext_ff;
   assign ext_flag     = ext_flag_ff;
   assign is_broadcast = bcast_ff;
   assign vpn_out      = vpn_out_ff;
endmodule

[rtl/r40c_decode.sv]
// Decode datapath: radix-40 digit extraction by reciprocal multiplication.
module r40c_decode (
   input  logic                           clock,
   input  r40c_pkg::stage_ctrl_type       ctrl,
   input  logic                           mode,
   input  logic [r40c_pkg::CODE_W-1:0]    code_main_in,
   input  logic [r40c_pkg::CODE_W-1:0]    code_ext_in,
   input  logic                           ext_present_in,
   output logic [r40c_pkg::CHARS_W-1:0]   chars_main_out,
   output logic [r40c_pkg::CHARS_W-1:0]   chars_ext_out
);
   import r40c_pkg::*;

   localparam int LANES  = 2;
   localparam int HALVES = 2 * LANES;
   localparam int PROD_W = 47;
   localparam int MUL3_W = 22;
   localparam int MUL5_W = 16;
   localparam int REM_W  = 11;

   typedef struct packed {
      logic mode;
      logic ext_present;
   } dec_tag_type;

   dec_tag_type        tag_in;
   dec_tag_type        tag_ff [STAGES-1];

   logic [CODE_W-1:0]  code_v [LANES];
   logic [PROD_W-1:0]  prod_in [LANES];
   logic [PROD_W-1:0]  prod_ff [LANES];
   logic [CODE_W-1:0]  code_ff [LANES];
   logic [HALF_W-1:0]  half_in [HALVES];
   logic [HALF_W-1:0]  half_ff [HALVES];
   logic [MUL3_W-1:0]  mul3_in [HALVES];
   logic [MUL3_W-1:0]  mul3_ff [HALVES];
   logic [HALF_W-1:0]  half3_ff [HALVES];
   sym_type            d0_in [HALVES];
   sym_type            d0_ff [HALVES];
   logic [REM_W-1:0]   rem_in [HALVES];
   logic [REM_W-1:0]   rem_ff [HALVES];
   logic [CHARS_W-1:0] chars_in [LANES];
   logic [CHARS_W-1:0] chars_ff [LANES];

   // Stage one: the chunk code over 64000 starts as a multiply by the reciprocal of 125.
   always_comb begin
      code_v[0] = code_main_in;
      code_v[1] = code_ext_in;
      for (int l = 0; l < LANES; l++) begin
         prod_in[l] = PROD_W'(code_v[l][CODE_W-1:9]) * PROD_W'(RECIP_125);
      end
      tag_in.mode        = mode;
      tag_in.ext_present = ext_present_in;
   end

   // Stage two: split each code into an upper and a lower three-digit half.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         logic [HALF_W-1:0] hi;
         logic [CODE_W-1:0] lo;
         hi = prod_ff[l][RECIP_125_SHIFT +: HALF_W];
         lo = code_ff[l] - (CODE_W'(hi) << 16) + (CODE_W'(hi) << 10)
              + (CODE_W'(hi) << 9);
         half_in[2*l]   = hi;
         half_in[2*l+1] = HALF_W'(lo[GROUP_W-1:0]);
      end
   end

   // Stages three and four: leading digit of each half, and the remainder below 1600.
   always_comb begin
      for (int h = 0; h < HALVES; h++) begin
         logic [SYM_W-1:0]  a;
         logic [HALF_W-1:0] a17;
         logic [HALF_W-1:0] r;
         mul3_in[h] = MUL3_W'(half_ff[h][HALF_W-1:6]) * MUL3_W'(RECIP_25);
         a   = mul3_ff[h][RECIP_25_SHIFT +: SYM_W];
         a17 = HALF_W'(a);
         r   = half3_ff[h] - (a17 << 10) - (a17 << 9) - (a17 << 6);
         rem_in[h] = r[REM_W-1:0];
         // Only the code modulo 40^6 counts, so the top digit wraps.
         d0_in[h]  = (a >= RADIX) ? a - RADIX : a;
      end
   end

   // Stage five: last two digits and the mapping back to ASCII.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         chars_in[l] = '0;
      end
      for (int h = 0; h < HALVES; h++) begin
         logic [MUL5_W-1:0] m;
         sym_type           d1;
         logic [REM_W-1:0]  d2w;
         m   = MUL5_W'(rem_ff[h][REM_W-1:3]) * MUL5_W'(RECIP_5);
         d1  = m[RECIP_5_SHIFT +: SYM_W];
         d2w = rem_ff[h] - (REM_W'(d1) << 5) - (REM_W'(d1) << 3);
         chars_in[h/2][(1 - h%2)*GROUP_CHARS*CHAR_W +: GROUP_CHARS*CHAR_W] =
            {char_of(d0_ff[h]), char_of(d1), char_of(d2w[SYM_W-1:0])};
      end
      if (!tag_ff[STAGES-2].mode) begin
         chars_in[0] = '0;
      end
      if (!tag_ff[STAGES-2].mode || !tag_ff[STAGES-2].ext_present) begin
         chars_in[1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         prod_ff   <= prod_in;
         code_ff   <= code_v;
         tag_ff[0] <= tag_in;
      end
      for (int i = 1; i < STAGES - 1; i++) begin
         if (ctrl.load[i]) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
      if (ctrl.load[1]) begin
         half_ff <= half_in;
      end
      if (ctrl.load[2]) begin
         mul3_ff  <= mul3_in;
         half3_ff <= half_ff;
      end
      if (ctrl.load[3]) begin
         d0_ff  <= d0_in;
         rem_ff <= rem_in;
      end
      if (ctrl.load[4]) begin
         chars_ff <= chars_in;
      end
   end

   assign chars_main_out = chars_ff[0];
   assign chars_ext_out  = chars_ff[1];
endmodule

[rtl/radix40_callsign_codec.sv]
// Top level of the radix-40 callsign codec: pipeline control and both datapaths.
//
// Requests arrive on req_bus and results leave on rsp_bus; both are valid/ready
// channels, and a transfer happens on a rising clock edge with valid and ready high.
// Each request carries a mode bit. Encode (mode 0) packs a callsign of up to twelve
// characters into two 32-bit radix-40 codes, with an extension flag and the broadcast
// callsign FFFF detected. Decode (mode 1) unpacks the two codes back into ASCII.
// Every request gives exactly one response, in request order.
// The pipeline has five register stages, and a response is presented on rsp_bus from
// the last of them. The depth is set by the decode path, which extracts the digits
// with a chain of reciprocal multiplies and subtractions; the encode path runs
// alongside it in the same stages. A new request can be taken in every cycle while
// the receiver is ready or a stage is empty.
// When the receiver stalls, the stages fill up and hold their contents; req_bus.ready
// stays high while an empty stage remains, so no request is lost or repeated.
// Synchronous reset empties the pipeline; data registers are not reset.
module radix40_callsign_codec (
   input  logic       clock,
   input  logic       reset,
   r40c_req_if.sink   req_bus,
   r40c_rsp_if.source rsp_bus
);
   import r40c_pkg::*;

   stage_ctrl_type ctrl;

   // Valid bits and load enables for all five stages.
   r40c_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctrl      (ctrl)
   );

   // The encode path yields zero codes in decode mode and the decode path yields
   // zero characters in encode mode, so the response fields need no further mux.
   r40c_encode u_encode (
      .clock        (clock),
      .ctrl         (ctrl),
      .mode         (req_bus.mode),
      .first_chars  (req_bus.first_chars),
      .ext_chars    (req_bus.ext_chars),
      .char_count   (req_bus.char_count),
      .vpn_in       (req_bus.vpn_in),
      .code_main    (rsp_bus.code_main),
      .code_ext     (rsp_bus.code_ext),
      .ext_flag     (rsp_bus.ext_flag),
      .is_broadcast (rsp_bus.is_broadcast),
      .vpn_out      (rsp_bus.vpn_out)
   );

   r40c_decode u_decode (
      .clock          (clock),
      .ctrl           (ctrl),
      .mode           (req_bus.mode),
      .code_main_in   (req_bus.code_main_in),
      .code_ext_in    (req_bus.code_ext_in),
      .ext_present_in (req_bus.ext_present_in),
      .chars_main_out (rsp_bus.chars_main_out),
      .chars_ext_out  (rsp_bus.chars_ext_out)
   );
endmodule

[rtl/r40c_checker.sv]
// Port-level assertions for the codec and the bind that attaches them.
module r40c_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [r40c_pkg::CODE_W-1:0]   rsp_code_main,
   input logic [r40c_pkg::CODE_W-1:0]   rsp_code_ext,
   input logic                          rsp_ext_flag,
   input logic                          rsp_is_broadcast,
   input logic [r40c_pkg::VPN_W-1:0]    rsp_vpn_out,
   input logic [r40c_pkg::CHARS_W-1:0]  rsp_chars_main,
   input logic [r40c_pkg::CHARS_W-1:0]  rsp_chars_ext
);
   import r40c_pkg::*;

   // A receiver that is ready always lets a new request in.
   a_ready_passes: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request refused while the receiver was ready");

   // A stalled response holds its value.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_code_main) && $stable(rsp_code_ext)
         && $stable(rsp_chars_main) && $stable(rsp_chars_ext) && $stable(rsp_vpn_out))
      else $error("stalled response changed");

   // A broadcast response carries the fixed broadcast codes and no extension.
   a_broadcast: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_broadcast |->
         rsp_code_main == BCAST_CODE && rsp_vpn_out == BCAST_VPN
         && !rsp_ext_flag && rsp_code_ext == '0)
      else $error("broadcast response fields inconsistent");

   // Decoded characters are never zero bytes, so they mark a decode response,
   // in which all encode fields stay clear.
   a_modes_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chars_main != '0 |->
         rsp_code_main == '0 && rsp_code_ext == '0 && !rsp_ext_flag && !rsp_is_broadcast)
      else $error("decode response carries encode fields");

   // Without the extension flag there is no extension code.
   a_ext_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ext_flag |-> rsp_code_ext == '0)
      else $error("extension code without extension flag");
endmodule

bind radix40_callsign_codec r40c_checker u_r40c_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_code_main    (rsp_bus.code_main),
   .rsp_code_ext     (rsp_bus.code_ext),
   .rsp_ext_flag     (rsp_bus.ext_flag),
   .rsp_is_broadcast (rsp_bus.is_broadcast),
   .rsp_vpn_out      (rsp_bus.vpn_out),
   .rsp_chars_main   (rsp_bus.chars_main_out),
   .rsp_chars_ext    (rsp_bus.chars_ext_out)
);
